// ===== rtl/bdg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdg_pkg: shared types and constants for the button debounce gesture unit
// Event codes, command codes, register indexes, reset values and the
// structs passed between the top level and the gesture core.
// ----------------------------------------------------------------------------
package bdg_pkg;

    localparam int TIME_W  = 32;
    localparam int TICKS_W = 16;
    localparam int CODE_W  = 3;
    localparam int COUNT_W = 3;
    localparam int CFG_IDX_W = 2;

    // Input command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    // Result event codes.
    localparam logic [CODE_W-1:0] EV_PRESS   = 3'd0;
    localparam logic [CODE_W-1:0] EV_RELEASE = 3'd1;
    localparam logic [CODE_W-1:0] EV_CLICK   = 3'd2;
    localparam logic [CODE_W-1:0] EV_DOUBLE  = 3'd3;
    localparam logic [CODE_W-1:0] EV_TRIPLE  = 3'd4;
    localparam logic [CODE_W-1:0] EV_HOLD    = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 2'd3;

    // Register reset values.
    localparam logic [TICKS_W-1:0] RST_PRESS_DB   = 16'd20;
    localparam logic [TICKS_W-1:0] RST_RELEASE_DB = 16'd20;
    localparam logic [TICKS_W-1:0] RST_HOLD       = 16'd1000;
    localparam logic [TICKS_W-1:0] RST_IDLE       = 16'd300;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

    typedef struct packed {
        logic [TICKS_W-1:0] press_db;
        logic [TICKS_W-1:0] release_db;
        logic [TICKS_W-1:0] hold_ticks;
        logic [TICKS_W-1:0] idle_ticks;
    } bdg_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] event_time;
    } bdg_result_t;

endpackage
`default_nettype wire

// ===== rtl/bdg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdg_core: debounce and gesture state
// Holds the tick clock, edge times, click count, hold lock and gesture
// timer, and works one tick or edge transaction per enabled cycle.
// ----------------------------------------------------------------------------
module bdg_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire logic                command,
    input  wire logic                pin_level,
    input  wire bdg_pkg::bdg_cfg_t   cfg,
    output bdg_pkg::bdg_result_t     result
);
    import bdg_pkg::*;

    logic [TIME_W-1:0]  tick_now_reg,      tick_now_next;
    logic [TIME_W-1:0]  press_time_reg,    press_time_next;
    logic [TIME_W-1:0]  release_time_reg,  release_time_next;
    logic [COUNT_W-1:0] click_count_reg,   click_count_next;
    logic               hold_lock_reg,     hold_lock_next;
    logic               timer_running_reg, timer_running_next;
    logic [TICKS_W-1:0] timer_left_reg,    timer_left_next;

    logic [TICKS_W-1:0] timer_dec;
    logic [TIME_W-1:0]  since_press;
    logic [TIME_W-1:0]  since_release;
    logic               still_held;

    assign timer_dec     = timer_left_reg - TICKS_W'(1);
    assign since_press   = tick_now_reg - press_time_reg;
    assign since_release = tick_now_reg - release_time_reg;
    assign still_held    = press_time_reg > release_time_reg;

    always_comb begin
        tick_now_next      = tick_now_reg;
        press_time_next    = press_time_reg;
        release_time_next  = release_time_reg;
        click_count_next   = click_count_reg;
        hold_lock_next     = hold_lock_reg;
        timer_running_next = timer_running_reg;
        timer_left_next    = timer_left_reg;
        result             = '0;

        if (step_en) begin
            if (command == CMD_TICK) begin
                tick_now_next = tick_now_reg + TIME_W'(1);
                if (timer_running_reg) begin
                    timer_left_next = timer_dec;
                    if (timer_dec == '0) begin
                        // Timer expiry: settle the gesture.
                        timer_running_next = 1'b0;
                        click_count_next   = '0;
                        result.event_time  = press_time_reg;
                        if (still_held) begin
                            if (!hold_lock_reg && click_count_reg == COUNT_W'(1)) begin
                                result.valid = 1'b1;
                                result.code  = EV_HOLD;
                            end
                            hold_lock_next = 1'b1;
                        end else begin
                            if (!hold_lock_reg) begin
                                case (click_count_reg)
                                    COUNT_W'(1): begin
                                        result.valid = 1'b1;
                                        result.code  = EV_CLICK;
                                    end
                                    COUNT_W'(2): begin
                                        result.valid = 1'b1;
                                        result.code  = EV_DOUBLE;
                                    end
                                    COUNT_W'(3): begin
                                        result.valid = 1'b1;
                                        result.code  = EV_TRIPLE;
                                    end
                                    default: begin
                                        result.valid = 1'b0;
                                    end
                                endcase
                            end
                            hold_lock_next = 1'b0;
                        end
                    end
                end
            end else if (pin_level) begin
                // Release edge; its time is stored even when it bounces.
                release_time_next = tick_now_reg;
                if (since_press >= {{(TIME_W-TICKS_W){1'b0}}, cfg.release_db}) begin
                    timer_running_next = 1'b1;
                    timer_left_next    = (cfg.idle_ticks == '0) ? TICKS_W'(1)
                                                                : cfg.idle_ticks;
                    result.valid       = 1'b1;
                    result.code        = EV_RELEASE;
                    result.event_time  = tick_now_reg;
                end
            end else begin
                press_time_next = tick_now_reg;
                if (since_release >= {{(TIME_W-TICKS_W){1'b0}}, cfg.press_db}) begin
                    if (!hold_lock_reg) begin
                        timer_running_next = 1'b1;
                        timer_left_next    = (cfg.hold_ticks == '0) ? TICKS_W'(1)
                                                                    : cfg.hold_ticks;
                        if (click_count_reg != COUNT_MAX) begin
                            click_count_next = click_count_reg + COUNT_W'(1);
                        end
                    end
                    result.valid      = 1'b1;
                    result.code       = EV_PRESS;
                    result.event_time = tick_now_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_now_reg      <= '0;
            press_time_reg    <= '0;
            release_time_reg  <= '0;
            click_count_reg   <= '0;
            hold_lock_reg     <= 1'b0;
            timer_running_reg <= 1'b0;
            timer_left_reg    <= '0;
        end else begin
            tick_now_reg      <= tick_now_next;
            press_time_reg    <= press_time_next;
            release_time_reg  <= release_time_next;
            click_count_reg   <= click_count_next;
            hold_lock_reg     <= hold_lock_next;
            timer_running_reg <= timer_running_next;
            timer_left_reg    <= timer_left_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/button_debounce_gesture_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_gesture_unit: button debounce and gesture detector
// Takes tick and pin-edge transactions and reports press, release, click,
// double click, triple click and hold events with their tick times.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                    tuser
//  s_axis    in         [0] pin_level, [7:1] 0   [0] command
//  m_axis    out        [31:0] event_time        [2:0] event_code
//  cfg       in         write only: cfg_we, cfg_index, cfg_wdata[15:0]
//
//  One transaction per cycle is sustained while m_axis is not stalled; each
//  is registered in the input register, worked by the gesture core once the
//  result register can take its result, and the result is loaded into the
//  result register that drives m_axis_tvalid. Only a stalled m_axis with a
//  result pending blocks the input register. Reset is synchronous, active low,
//  and restores the valid flags, the core state and the register reset values.
// ----------------------------------------------------------------------------
module button_debounce_gesture_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [0] pin_level
    input  wire logic                           s_axis_tuser,  // [0] command
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [bdg_pkg::TIME_W-1:0]          m_axis_tdata,  // [31:0] event_time
    output logic [bdg_pkg::CODE_W-1:0]          m_axis_tuser,  // [2:0] event_code
    input  wire logic                           cfg_we,
    input  wire logic [bdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bdg_pkg::TICKS_W-1:0]    cfg_wdata
);
    import bdg_pkg::*;

    bdg_cfg_t cfg_reg;

    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic              in_pin_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              advance;
    bdg_result_t       step_res;

    // The working stage moves only when the result register can take a result.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_db   <= RST_PRESS_DB;
            cfg_reg.release_db <= RST_RELEASE_DB;
            cfg_reg.hold_ticks <= RST_HOLD;
            cfg_reg.idle_ticks <= RST_IDLE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PRESS_DB:   cfg_reg.press_db   <= cfg_wdata;
                REG_RELEASE_DB: cfg_reg.release_db <= cfg_wdata;
                REG_HOLD:       cfg_reg.hold_ticks <= cfg_wdata;
                REG_IDLE:       cfg_reg.idle_ticks <= cfg_wdata;
                default:        cfg_reg.press_db   <= cfg_reg.press_db;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg <= s_axis_tuser;
            in_pin_reg <= s_axis_tdata[0];
        end
    end

    bdg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .command   (in_cmd_reg),
        .pin_level (in_pin_reg),
        .cfg       (cfg_reg),
        .result    (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_res.valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && step_res.valid) begin
            out_code_reg <= step_res.code;
            out_time_reg <= step_res.event_time;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_time_reg;
    assign m_axis_tuser  = out_code_reg;

    // A busy input stage is the only reason to refuse a transaction.
    a_ready_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> in_valid_reg)
        else $error("input refused while the input stage is empty");

    // A transaction held behind a stalled result must not be dropped.
    a_no_drop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_axis_tready |=> in_valid_reg)
        else $error("pending transaction lost during output stall");

    // A new result may only be loaded when the previous one has been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_time_reg)
            && $stable(out_code_reg))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
